### rtl/core/rmsg_pkg.sv
// Shared constants, codes and payload types for the running mean / std-dev unit.
// Used by rmsg_serial_alu and running_mean_stddev_goal_unit; no dependencies.
package rmsg_pkg;

  localparam int COUNT_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int SUM_W      = DATA_W + COUNT_BITS;
  localparam int WIDE_W     = 2 * DATA_W;
  localparam int REM_W      = DATA_W + 2;
  localparam int STEP_W     = $clog2(WIDE_W + 1);

  localparam logic [DATA_W-1:0] ABORT_BELOW_RESET = DATA_W'(5 << FRAC_BITS);

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [1:0] KIND_FEEDBACK  = 2'd0;
  localparam logic [1:0] KIND_SUCCEEDED = 2'd1;
  localparam logic [1:0] KIND_ABORTED   = 2'd2;
  localparam logic [1:0] KIND_PREEMPTED = 2'd3;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic    go;
    alu_op_t op;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] sample_value;
    logic [COUNT_BITS-1:0]    goal_count;
  } req_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [COUNT_BITS-1:0]    sample_count;
    logic signed [DATA_W-1:0] sample_echo;
    logic signed [DATA_W-1:0] mean;
    logic [DATA_W-1:0]        std_dev;
    logic                     last;
  } rsp_t;

endpackage

### rtl/core/rmsg_serial_alu.sv
// Bit-serial arithmetic unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one result bit per cycle. Depends on rmsg_pkg.
module rmsg_serial_alu
  import rmsg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  alu_cmd_t          cmd,
  input  logic [WIDE_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output alu_sts_t          sts,
  output logic [WIDE_W-1:0] result
);

  alu_op_t           op;
  logic [WIDE_W-1:0] wk, wk_next;
  logic [REM_W-1:0]  part, part_next;
  logic [DATA_W-1:0] opnd, opnd_next;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;

  logic [DATA_W:0]     mul_sum;
  logic [COUNT_BITS:0] div_trial;
  logic                div_ge;
  logic [REM_W+1:0]    sq_trial;
  logic [REM_W+1:0]    sq_test;
  logic                sq_ge;

  always_comb begin
    mul_sum   = {1'b0, wk[WIDE_W-1:DATA_W]} + (wk[0] ? {1'b0, opnd} : '0);
    div_trial = {part[COUNT_BITS-1:0], wk[WIDE_W-1]};
    div_ge    = div_trial >= {1'b0, opnd[COUNT_BITS-1:0]};
    sq_trial  = {part, wk[WIDE_W-1 -: 2]};
    sq_test   = {{(REM_W-DATA_W){1'b0}}, opnd, 2'b01};
    sq_ge     = sq_trial >= sq_test;

    wk_next   = wk;
    part_next = part;
    opnd_next = opnd;
    unique case (op)
      OP_MUL: begin
        // add multiplicand into the high half, shift product right
        wk_next = {mul_sum, wk[DATA_W-1:1]};
      end
      OP_DIV: begin
        wk_next   = {wk[WIDE_W-2:0], div_ge};
        part_next = div_ge ? REM_W'(div_trial - {1'b0, opnd[COUNT_BITS-1:0]})
                           : REM_W'(div_trial);
      end
      OP_SQRT: begin
        // bring down two radicand bits, try root*4+1
        wk_next   = {wk[WIDE_W-3:0], 2'b00};
        part_next = sq_ge ? REM_W'(sq_trial - sq_test) : REM_W'(sq_trial);
        opnd_next = {opnd[DATA_W-2:0], sq_ge};
      end
      default: begin
        wk_next = wk;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.go) begin
        busy  <= 1'b1;
        steps <= (cmd.op == OP_DIV) ? STEP_W'(WIDE_W) : STEP_W'(DATA_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      op   <= cmd.op;
      part <= '0;
      unique case (cmd.op)
        OP_MUL: begin
          wk   <= {{(WIDE_W-DATA_W){1'b0}}, a[DATA_W-1:0]};
          opnd <= b;
        end
        OP_DIV: begin
          wk   <= a;
          opnd <= b;
        end
        OP_SQRT: begin
          wk   <= a;
          opnd <= '0;
        end
        default: begin
          wk   <= a;
          opnd <= b;
        end
      endcase
    end else if (busy) begin
      wk   <= wk_next;
      part <= part_next;
      opnd <= opnd_next;
    end
  end

  assign sts    = '{busy: busy, done: done};
  assign result = (op == OP_SQRT) ? {{(WIDE_W-DATA_W){1'b0}}, opnd} : wk;

endmodule

### rtl/core/running_mean_stddev_goal_unit.sv
// A sample request runs the square, mean divide, mean-square divide, mean^2 and
// root steps in order in the shared serial ALU. Requests stall until the result,
// and any terminal result that follows it, has been taken; start is handled in
// idle, and cancel gives its own result. Synchronous reset clears the job, count,
// goal and sums, and sets abort_below to 5.0. Depends on rmsg_pkg.
module running_mean_stddev_goal_unit
  import rmsg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_MEAN = 7'b0000100,
    S_EX2  = 7'b0001000,
    S_M2   = 7'b0010000,
    S_ROOT = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic signed [DATA_W-1:0] abort_below;
  logic                     active;
  logic [COUNT_BITS-1:0]    count;
  logic [COUNT_BITS-1:0]    goal;
  logic [SUM_W-1:0]         sum;
  logic [WIDE_W-1:0]        sqsum;
  logic                     term_pending;

  logic signed [DATA_W-1:0] sample;
  logic                     skip;
  logic                     finish;
  logic [DATA_W-1:0]        q;
  logic [WIDE_W-1:0]        ex2;
  logic [1:0]               term_kind;

  logic              req_fire;
  logic              rsp_fire;
  logic [DATA_W-1:0] smag_in;
  logic              count_full;
  logic              finish_in;
  logic [SUM_W-1:0]  sum_mag;
  logic [WIDE_W:0]   sq_add;
  logic [WIDE_W-1:0] m2;
  logic [WIDE_W-1:0] var_abs;
  logic [WIDE_W-1:0] radicand;
  logic [DATA_W-1:0] mean_val;
  logic              mean_low;

  alu_cmd_t          alu_cmd;
  alu_sts_t          alu_sts;
  logic [WIDE_W-1:0] alu_a;
  logic [DATA_W-1:0] alu_b;
  logic [WIDE_W-1:0] alu_res;

  rmsg_serial_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (alu_cmd),
    .a      (alu_a),
    .b      (alu_b),
    .sts    (alu_sts),
    .result (alu_res)
  );

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign rsp_valid = (state == S_EMIT);
  assign rsp_fire  = rsp_valid && !rsp_stall;

  always_comb begin
    smag_in    = req.sample_value[DATA_W-1] ? (~req.sample_value) + 1'b1 : req.sample_value;
    count_full = (count == '1);
    finish_in  = ({1'b0, count} + 1'b1) > {1'b0, goal};
    sum_mag    = sum[SUM_W-1] ? (~sum) + 1'b1 : sum;
    sq_add     = {1'b0, sqsum} + {1'b0, alu_res >> FRAC_BITS};
    m2         = alu_res >> FRAC_BITS;
    var_abs    = (ex2 >= m2) ? ex2 - m2 : m2 - ex2;
    radicand   = var_abs << FRAC_BITS;
    mean_val   = sum[SUM_W-1] ? (~q) + 1'b1 : q;
    mean_low   = $signed(mean_val) < abort_below;
  end

  // issue the next serial operation as the previous one finishes
  always_comb begin
    alu_cmd = '{go: 1'b0, op: OP_MUL};
    alu_a   = '0;
    alu_b   = '0;
    unique case (state)
      S_IDLE: begin
        if (req_fire && req.cmd == CMD_SAMPLE && active) begin
          alu_cmd = '{go: 1'b1, op: OP_MUL};
          alu_a   = {{(WIDE_W-DATA_W){1'b0}}, smag_in};
          alu_b   = smag_in;
        end
      end
      S_SQ: begin
        if (alu_sts.done) begin
          alu_cmd = '{go: 1'b1, op: OP_DIV};
          alu_a   = {{(WIDE_W-SUM_W){1'b0}}, sum_mag};
          alu_b   = {{(DATA_W-COUNT_BITS){1'b0}}, count};
        end
      end
      S_MEAN: begin
        if (alu_sts.done) begin
          alu_cmd = '{go: 1'b1, op: OP_DIV};
          alu_a   = sqsum;
          alu_b   = {{(DATA_W-COUNT_BITS){1'b0}}, count};
        end
      end
      S_EX2: begin
        if (alu_sts.done) begin
          alu_cmd = '{go: 1'b1, op: OP_MUL};
          alu_a   = {{(WIDE_W-DATA_W){1'b0}}, q};
          alu_b   = q;
        end
      end
      S_M2: begin
        if (alu_sts.done) begin
          alu_cmd = '{go: 1'b1, op: OP_SQRT};
          alu_a   = radicand;
        end
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire && active &&
            (req.cmd == CMD_SAMPLE || req.cmd == CMD_CANCEL)) begin
          state_next = (req.cmd == CMD_SAMPLE) ? S_SQ : S_EMIT;
        end
      end
      S_SQ:   if (alu_sts.done) state_next = S_MEAN;
      S_MEAN: if (alu_sts.done) state_next = S_EX2;
      S_EX2:  if (alu_sts.done) state_next = S_M2;
      S_M2:   if (alu_sts.done) state_next = S_ROOT;
      S_ROOT: if (alu_sts.done) state_next = S_EMIT;
      S_EMIT: if (rsp_fire && !term_pending) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      abort_below  <= ABORT_BELOW_RESET;
      active       <= 1'b0;
      count        <= '0;
      goal         <= '0;
      sum          <= '0;
      sqsum        <= '0;
      term_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        abort_below <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (req.cmd == CMD_START) begin
              goal   <= req.goal_count;
              count  <= '0;
              sum    <= '0;
              sqsum  <= '0;
              active <= 1'b1;
            end else if (req.cmd == CMD_CANCEL && active) begin
              active       <= 1'b0;
              term_pending <= 1'b0;
            end else if (req.cmd == CMD_SAMPLE && active && !count_full) begin
              count <= count + 1'b1;
              sum   <= sum + {{(SUM_W-DATA_W){req.sample_value[DATA_W-1]}},
                              req.sample_value};
            end
          end
        end
        S_SQ: begin
          // saturate the square sum on carry out
          if (alu_sts.done && !skip) begin
            sqsum <= sq_add[WIDE_W] ? '1 : sq_add[WIDE_W-1:0];
          end
        end
        S_ROOT: begin
          if (alu_sts.done) begin
            term_pending <= finish;
            if (finish) begin
              active <= 1'b0;
            end
          end
        end
        S_EMIT: begin
          if (rsp_fire) begin
            term_pending <= 1'b0;
          end
        end
        default: begin
          term_pending <= term_pending;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      sample <= req.sample_value;
      skip   <= count_full;
      finish <= finish_in;
      if (req.cmd == CMD_CANCEL && active) begin
        rsp <= '{kind: KIND_PREEMPTED, sample_count: count, sample_echo: '0,
                 mean: '0, std_dev: '0, last: 1'b1};
      end
    end
    if (state == S_MEAN && alu_sts.done) begin
      q <= alu_res[DATA_W-1:0];
    end
    if (state == S_EX2 && alu_sts.done) begin
      ex2 <= alu_res;
    end
    if (state == S_ROOT && alu_sts.done) begin
      rsp <= '{kind: KIND_FEEDBACK, sample_count: count, sample_echo: sample,
               mean: mean_val, std_dev: alu_res[DATA_W-1:0], last: !finish};
      term_kind <= mean_low ? KIND_ABORTED : KIND_SUCCEEDED;
    end
    // hold the feedback values, switch to the terminal kind
    if (state == S_EMIT && rsp_fire && term_pending) begin
      rsp.kind <= term_kind;
      rsp.last <= 1'b1;
    end
  end

  a_rsp_blocks_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while a result is pending");

  a_alu_free: assert property (@(posedge clk) disable iff (rst)
    alu_cmd.go |-> !alu_sts.busy)
    else $error("serial ALU restarted while busy");

  a_alu_needs_job: assert property (@(posedge clk) disable iff (rst)
    alu_cmd.go |-> active)
    else $error("sample work started with no active job");

  a_terminal_follows: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && !rsp.last |=>
      rsp_valid && (rsp.kind == KIND_SUCCEEDED || rsp.kind == KIND_ABORTED))
    else $error("feedback without last not followed by terminal result");

endmodule
